FILE: rtl/etxnps_pkg.sv
// Shared types, constants and helper functions of the neighbor table parent select block.
package etxnps_pkg;

    localparam int TABLE_DEPTH   = 16;
    localparam int ID_W          = 16;
    localparam int ETX_FRAC_BITS = 8;
    localparam int ETX_W         = 12 + ETX_FRAC_BITS;
    localparam int LFSR_W        = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 20;
    localparam int LIMIT_W       = 5;

    localparam logic [ETX_W-1:0]  ETX_MAX    = {ETX_W{1'b1}};
    localparam logic [ETX_W-1:0]  BEST_START = ETX_W'(999) << ETX_FRAC_BITS;
    localparam logic [LFSR_W-1:0] LFSR_TAPS  = 16'hB400;

    localparam logic [LIMIT_W-1:0] LIMIT_RST     = 5'd10;
    localparam logic [ETX_W-1:0]   EVICT_THR_RST = 20'd1280;
    localparam logic [ETX_W-1:0]   MARGIN_RST    = 20'd384;
    localparam logic [ETX_W-1:0]   UNREACH_RST   = 20'd2560;
    localparam logic [LFSR_W-1:0]  SEED_RST      = 16'd44257;

    localparam logic [1:0] REQ_LINK  = 2'd0;
    localparam logic [1:0] REQ_ROUTE = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_ID   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EVICT_THR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UNREACH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED      = 3'd6;

    typedef struct packed {
        logic [ID_W-1:0]  parent;
        logic             path_ok;
        logic [ETX_W-1:0] path;
        logic             link_ok;
        logic [ETX_W-1:0] link;
        logic [ID_W-1:0]  node;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_EVICT,
        ST_INSERT,
        ST_DIV,
        ST_RANK,
        ST_SELECT,
        ST_SWITCH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              start;
        logic [LFSR_W-1:0] dividend;
    } t_div_req;

    function automatic logic [ETX_W-1:0] sat_add(input logic [ETX_W-1:0] a,
                                                 input logic [ETX_W-1:0] b);
        logic [ETX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ETX_W] ? ETX_MAX : s[ETX_W-1:0];
    endfunction

    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
        return v[0] ? ((v >> 1) ^ LFSR_TAPS) : (v >> 1);
    endfunction

endpackage

FILE: rtl/etxnps_mem.sv
// Neighbor table storage: one write port, one read port, registered read data.
module etxnps_mem #(
    parameter int DEPTH = etxnps_pkg::TABLE_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [AW-1:0]                i_waddr,
    input  etxnps_pkg::t_entry           i_wdata,
    input  logic                         i_re,
    input  logic [AW-1:0]                i_raddr,
    output etxnps_pkg::t_entry           o_rdata
);

    etxnps_pkg::t_entry r_mem [DEPTH];
    etxnps_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/etxnps_div.sv
// Bit-serial remainder unit: dividend modulo a small divisor, one bit per cycle.
module etxnps_div #(
    parameter int CW = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  etxnps_pkg::t_div_req i_req,
    input  logic [CW-1:0]       i_divisor,
    output logic                o_done,
    output logic [CW-1:0]       o_rem
);

    localparam int DW = etxnps_pkg::LFSR_W;
    localparam int SW = $clog2(DW);

    logic            r_busy;
    logic            r_done;
    logic [SW-1:0]   r_step;
    logic [DW-1:0]   r_q;
    logic [CW-1:0]   r_rem;
    logic [CW:0]     trial;
    logic [CW:0]     n_rem;

    always_comb begin
        trial = {r_rem, r_q[DW-1]};
        if (trial >= {1'b0, i_divisor}) begin
            n_rem = trial - {1'b0, i_divisor};
        end else begin
            n_rem = trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == SW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= r_q << 1;
            r_rem <= n_rem[CW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

FILE: rtl/etx_neighbor_table_parent_select_core.sv
// Top level: neighbor table with eviction, parent selection and path ETX update.
//
// Requests enter on the s_axis channel: tuser carries the request type (link ETX
// update, route report, clear), tdata the node id, ETX value, its valid flag and
// the reported parent. Each request yields exactly one result word on m_axis.
// Registers are written on the cfg channel, which is always ready; write only
// while no request is in flight.
// Timing: one request at a time. A table scan reads one entry per cycle from the
// table memory. An update or insert costs two scans plus the decide, switch and
// result steps, and an insert adds an insert step; clear, root and unused types
// go straight to the result step. A forced eviction toward the sink adds the LFSR
// remainder and one scan per rank step, up to entry_count scans.
// The result sits in an output register; the next request is taken while it
// waits, but the following result waits until m_axis is free.
// Reset empties the table, drops parent and path, loads the register defaults
// and seeds the LFSR. No clearing pass is needed: slot valid bits are flops.
module etx_neighbor_table_parent_select_core #(
    parameter int TABLE_DEPTH = etxnps_pkg::TABLE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // node_id[15:0], etx_value[35:16], etx_valid[36], neighbour_parent[52:37]
    input  logic [55:0] i_s_axis_tdata,
    // req_type[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // parent_id[15:0], parent_valid[16], path_etx[36:17], path_valid[37],
    // parent_changed[38], path_changed[39], pull_request[40], entry_stored[41],
    // evicted_valid[42], evicted_id[58:43]
    output logic [63:0] o_m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [etxnps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [etxnps_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int ID_W  = etxnps_pkg::ID_W;
    localparam int ETX_W = etxnps_pkg::ETX_W;
    localparam logic [AW:0] CNT_END = (AW + 1)'(TABLE_DEPTH);

    etxnps_pkg::t_state r_state, n_state;

    logic [ID_W-1:0]  r_own, r_root;
    logic [etxnps_pkg::LIMIT_W-1:0] r_limit;
    logic [ETX_W-1:0] r_thr, r_margin, r_unr;
    logic [etxnps_pkg::LFSR_W-1:0] r_lfsr;

    logic [1:0]       r_req;
    logic [ID_W-1:0]  r_id, r_np;
    logic [ETX_W-1:0] r_ev;
    logic             r_evv;

    logic [TABLE_DEPTH-1:0] r_used;
    logic [CW-1:0]    r_count;
    logic             r_cur_ok;
    logic [ID_W-1:0]  r_cur_id;
    logic             r_cpath_ok, r_start_ok;
    logic [ETX_W-1:0] r_cpath, r_start;

    logic             r_pchg, r_pull, r_stored, r_evk;
    logic [ID_W-1:0]  r_evid;

    logic [AW:0]      r_cnt;
    logic             r_rd_vld;
    logic [AW-1:0]    r_rd_idx;

    logic             r_fnd;
    logic [AW-1:0]    r_fnd_idx;
    etxnps_pkg::t_entry r_fnd_e;
    logic             r_r1_ok, r_r2_ok;
    logic [AW-1:0]    r_r1_idx, r_r2_idx;
    logic [ETX_W-1:0] r_r1_link;
    logic [ID_W-1:0]  r_r1_node, r_r2_node;

    logic [AW-1:0]    r_v_idx;
    logic [ID_W-1:0]  r_v_node;

    logic [CW-1:0]    r_k, r_rank;
    logic             r_prev_ok, r_mn_ok;
    logic [ID_W-1:0]  r_prev, r_mn_node;
    logic [AW-1:0]    r_mn_idx;

    logic             r_b_ok, r_p_ok;
    logic [ID_W-1:0]  r_b_node;
    logic [ETX_W-1:0] r_b_path, r_b_link, r_b_sum;
    etxnps_pkg::t_entry r_p_e;

    logic             r_m_valid;
    logic [63:0]      r_m_data;

    etxnps_pkg::t_entry rd_e, wr_e;
    logic             we, rd_en, scan_state, scan_start, scan_done, in_acc, u;
    logic [AW-1:0]    wr_idx;
    logic             is_root, unreach, has_room, free_ok;
    logic [AW-1:0]    free_idx;
    logic [CW-1:0]    lim_eff;
    logic [ETX_W-1:0] rd_sum, adopt_sum, keep_sum;
    logic             adopt;
    etxnps_pkg::t_entry upd_e, new_e;
    etxnps_pkg::t_div_req div_req;
    logic             div_done;
    logic [CW-1:0]    div_rem;
    logic [ETX_W-1:0] in_ev;
    logic [ID_W-1:0]  in_id, in_np;
    logic             in_evv;
    logic [63:0]      out_word;

    assign in_id  = i_s_axis_tdata[15:0];
    assign in_ev  = i_s_axis_tdata[35:16];
    assign in_evv = i_s_axis_tdata[36];
    assign in_np  = i_s_axis_tdata[52:37];

    assign o_s_axis_tready = (r_state == etxnps_pkg::ST_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;
    assign is_root         = (r_own == r_root);

    always_comb begin
        if (r_limit == '0) begin
            lim_eff = CW'(1);
        end else if (32'(r_limit) > TABLE_DEPTH) begin
            lim_eff = CW'(TABLE_DEPTH);
        end else begin
            lim_eff = CW'(r_limit);
        end
    end
    assign has_room = (r_count < lim_eff);
    assign unreach  = (r_req == etxnps_pkg::REQ_LINK) && r_fnd && r_evv && (r_ev > r_unr);

    always_comb begin
        free_ok  = 1'b0;
        free_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_ok  = 1'b1;
                free_idx = AW'(i);
            end
        end
    end

    always_comb begin
        upd_e = r_fnd_e;
        new_e = '0;
        new_e.node = r_id;
        if (r_req == etxnps_pkg::REQ_LINK) begin
            upd_e.link_ok = r_evv;
            upd_e.link    = r_evv ? r_ev : '0;
            new_e.link_ok = r_evv;
            new_e.link    = r_evv ? r_ev : '0;
        end else begin
            upd_e.path_ok = r_evv;
            upd_e.path    = r_evv ? r_ev : '0;
            upd_e.parent  = r_np;
            new_e.path_ok = r_evv;
            new_e.path    = r_evv ? r_ev : '0;
            new_e.parent  = r_np;
        end
    end

    assign scan_state = (r_state == etxnps_pkg::ST_SCAN) || (r_state == etxnps_pkg::ST_RANK) ||
                        (r_state == etxnps_pkg::ST_SELECT);
    assign rd_en      = scan_state && (r_cnt != CNT_END);
    assign scan_done  = scan_state && (r_cnt == CNT_END) && !r_rd_vld;
    assign u          = r_used[r_rd_idx];
    assign rd_sum     = etxnps_pkg::sat_add(rd_e.path, rd_e.link);

    assign adopt      = r_b_ok && (!r_cur_ok || (r_p_ok && r_p_e.path_ok &&
                        (etxnps_pkg::sat_add(r_b_path, r_margin) < r_p_e.path)));
    assign adopt_sum  = etxnps_pkg::sat_add(r_b_path, r_b_link);
    assign keep_sum   = etxnps_pkg::sat_add(r_p_e.path, r_p_e.link);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= etxnps_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        scan_start       = 1'b0;
        we               = 1'b0;
        wr_idx           = r_fnd_idx;
        wr_e             = upd_e;
        div_req.start    = 1'b0;
        div_req.dividend = etxnps_pkg::lfsr_step(r_lfsr);
        case (r_state)
            etxnps_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_s_axis_tuser == etxnps_pkg::REQ_LINK ||
                        i_s_axis_tuser == etxnps_pkg::REQ_ROUTE) begin
                        if (is_root) begin
                            n_state = etxnps_pkg::ST_DONE;
                        end else begin
                            n_state    = etxnps_pkg::ST_SCAN;
                            scan_start = 1'b1;
                        end
                    end else begin
                        n_state = etxnps_pkg::ST_DONE;
                    end
                end
            end
            etxnps_pkg::ST_SCAN: begin
                if (scan_done) begin
                    n_state = etxnps_pkg::ST_DECIDE;
                end
            end
            etxnps_pkg::ST_DECIDE: begin
                if (unreach) begin
                    n_state    = etxnps_pkg::ST_SELECT;
                    scan_start = 1'b1;
                end else if (r_fnd) begin
                    we         = 1'b1;
                    n_state    = etxnps_pkg::ST_SELECT;
                    scan_start = 1'b1;
                end else if (has_room) begin
                    n_state = etxnps_pkg::ST_INSERT;
                end else if (r_r1_ok || r_r2_ok) begin
                    n_state = etxnps_pkg::ST_EVICT;
                end else if (r_id == r_root && r_count != '0) begin
                    div_req.start = 1'b1;
                    n_state       = etxnps_pkg::ST_DIV;
                end else begin
                    n_state    = etxnps_pkg::ST_SELECT;
                    scan_start = 1'b1;
                end
            end
            etxnps_pkg::ST_EVICT: begin
                n_state = etxnps_pkg::ST_INSERT;
            end
            etxnps_pkg::ST_INSERT: begin
                we         = free_ok;
                wr_idx     = free_idx;
                wr_e       = new_e;
                n_state    = etxnps_pkg::ST_SELECT;
                scan_start = 1'b1;
            end
            etxnps_pkg::ST_DIV: begin
                if (div_done) begin
                    n_state    = etxnps_pkg::ST_RANK;
                    scan_start = 1'b1;
                end
            end
            etxnps_pkg::ST_RANK: begin
                if (scan_done) begin
                    if (r_rank == r_k) begin
                        n_state = etxnps_pkg::ST_EVICT;
                    end else begin
                        scan_start = 1'b1;
                    end
                end
            end
            etxnps_pkg::ST_SELECT: begin
                if (scan_done) begin
                    n_state = etxnps_pkg::ST_SWITCH;
                end
            end
            etxnps_pkg::ST_SWITCH: begin
                n_state = etxnps_pkg::ST_DONE;
            end
            etxnps_pkg::ST_DONE: begin
                if (!r_m_valid || i_m_axis_tready) begin
                    n_state = etxnps_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = etxnps_pkg::ST_IDLE;
            end
        endcase
    end

    etxnps_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (wr_idx),
        .i_wdata (wr_e),
        .i_re    (rd_en),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (rd_e)
    );

    etxnps_div #(
        .CW (CW)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (div_req),
        .i_divisor (r_count),
        .o_done    (div_done),
        .o_rem     (div_rem)
    );

    // scan engine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= rd_en;
            if (scan_start) begin
                r_cnt <= '0;
            end else if (rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_cnt[AW-1:0];
    end

    // configuration, table state, parent state, flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own      <= '0;
            r_root     <= '0;
            r_limit    <= etxnps_pkg::LIMIT_RST;
            r_thr      <= etxnps_pkg::EVICT_THR_RST;
            r_margin   <= etxnps_pkg::MARGIN_RST;
            r_unr      <= etxnps_pkg::UNREACH_RST;
            r_lfsr     <= etxnps_pkg::SEED_RST;
            r_used     <= '0;
            r_count    <= '0;
            r_cur_ok   <= 1'b0;
            r_cur_id   <= '0;
            r_cpath_ok <= 1'b0;
            r_cpath    <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    etxnps_pkg::CFG_OWN_ID:    r_own    <= i_cfg_data[ID_W-1:0];
                    etxnps_pkg::CFG_ROOT_ID:   r_root   <= i_cfg_data[ID_W-1:0];
                    etxnps_pkg::CFG_LIMIT:     r_limit  <= i_cfg_data[etxnps_pkg::LIMIT_W-1:0];
                    etxnps_pkg::CFG_EVICT_THR: r_thr    <= i_cfg_data[ETX_W-1:0];
                    etxnps_pkg::CFG_MARGIN:    r_margin <= i_cfg_data[ETX_W-1:0];
                    etxnps_pkg::CFG_UNREACH:   r_unr    <= i_cfg_data[ETX_W-1:0];
                    etxnps_pkg::CFG_SEED: begin
                        r_lfsr <= (i_cfg_data[etxnps_pkg::LFSR_W-1:0] == '0) ?
                                  etxnps_pkg::LFSR_W'(1) : i_cfg_data[etxnps_pkg::LFSR_W-1:0];
                    end
                    default: ;
                endcase
            end

            if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                etxnps_pkg::ST_IDLE: begin
                    if (in_acc && i_s_axis_tuser == etxnps_pkg::REQ_CLEAR) begin
                        r_used     <= '0;
                        r_count    <= '0;
                        r_cur_ok   <= 1'b0;
                        r_cur_id   <= '0;
                        r_cpath_ok <= 1'b0;
                        r_cpath    <= '0;
                    end
                end
                etxnps_pkg::ST_DECIDE: begin
                    if (unreach) begin
                        r_used[r_fnd_idx] <= 1'b0;
                        r_count           <= r_count - 1'b1;
                        if (r_cur_ok && r_cur_id == r_id) begin
                            r_cur_ok   <= 1'b0;
                            r_cur_id   <= '0;
                            r_cpath_ok <= 1'b0;
                            r_cpath    <= '0;
                        end
                    end else if (!r_fnd && !has_room && !r_r1_ok && !r_r2_ok &&
                                 r_id == r_root && r_count != '0) begin
                        r_lfsr <= div_req.dividend;
                    end
                end
                etxnps_pkg::ST_EVICT: begin
                    r_used[r_v_idx] <= 1'b0;
                    r_count         <= r_count - 1'b1;
                    if (r_cur_ok && r_cur_id == r_v_node) begin
                        r_cur_ok   <= 1'b0;
                        r_cur_id   <= '0;
                        r_cpath_ok <= 1'b0;
                        r_cpath    <= '0;
                    end
                end
                etxnps_pkg::ST_INSERT: begin
                    if (free_ok) begin
                        r_used[free_idx] <= 1'b1;
                        r_count          <= r_count + 1'b1;
                    end
                end
                etxnps_pkg::ST_SWITCH: begin
                    if (adopt) begin
                        r_cur_ok   <= 1'b1;
                        r_cur_id   <= r_b_node;
                        r_cpath_ok <= 1'b1;
                        r_cpath    <= adopt_sum;
                    end else if (r_cur_ok) begin
                        if (r_p_ok && r_p_e.path_ok && r_p_e.link_ok) begin
                            r_cpath_ok <= 1'b1;
                            r_cpath    <= keep_sum;
                        end else begin
                            r_cpath_ok <= 1'b0;
                            r_cpath    <= '0;
                        end
                    end
                end
                etxnps_pkg::ST_DONE: begin
                    if (!r_m_valid || i_m_axis_tready) begin
                        r_m_valid <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // request capture, result flags and scan trackers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req      <= i_s_axis_tuser;
            r_id       <= in_id;
            r_ev       <= in_ev;
            r_evv      <= in_evv;
            r_np       <= in_np;
            r_start_ok <= r_cpath_ok;
            r_start    <= r_cpath;
            r_pchg     <= 1'b0;
            r_pull     <= 1'b0;
            r_stored   <= 1'b0;
            r_evk      <= 1'b0;
            r_evid     <= '0;
            r_fnd      <= 1'b0;
            r_r1_ok    <= 1'b0;
            r_r2_ok    <= 1'b0;
        end

        case (r_state)
            etxnps_pkg::ST_SCAN: begin
                if (r_rd_vld && u) begin
                    if (rd_e.node == r_id) begin
                        r_fnd     <= 1'b1;
                        r_fnd_idx <= r_rd_idx;
                        r_fnd_e   <= rd_e;
                    end
                    if (rd_e.node != r_root && rd_e.link_ok && rd_e.link >= r_thr &&
                        (!r_r1_ok || rd_e.link > r_r1_link ||
                         (rd_e.link == r_r1_link && rd_e.node < r_r1_node))) begin
                        r_r1_ok   <= 1'b1;
                        r_r1_idx  <= r_rd_idx;
                        r_r1_link <= rd_e.link;
                        r_r1_node <= rd_e.node;
                    end
                    if (rd_e.node != r_root && rd_e.path_ok &&
                        !(r_req == etxnps_pkg::REQ_ROUTE && r_evv && rd_e.path <= r_ev) &&
                        (!r_r2_ok || rd_e.node > r_r2_node)) begin
                        r_r2_ok   <= 1'b1;
                        r_r2_idx  <= r_rd_idx;
                        r_r2_node <= rd_e.node;
                    end
                end
            end
            etxnps_pkg::ST_DECIDE: begin
                if (unreach) begin
                    r_pull <= r_cur_ok && r_cur_id == r_id;
                    r_evk  <= 1'b1;
                    r_evid <= r_id;
                end else if (r_fnd) begin
                    r_stored <= 1'b1;
                end
                if (r_r1_ok) begin
                    r_v_idx  <= r_r1_idx;
                    r_v_node <= r_r1_node;
                end else begin
                    r_v_idx  <= r_r2_idx;
                    r_v_node <= r_r2_node;
                end
            end
            etxnps_pkg::ST_EVICT: begin
                r_evk  <= 1'b1;
                r_evid <= r_v_node;
            end
            etxnps_pkg::ST_INSERT: begin
                r_stored <= free_ok;
            end
            etxnps_pkg::ST_DIV: begin
                r_k       <= div_rem;
                r_rank    <= '0;
                r_prev_ok <= 1'b0;
                r_mn_ok   <= 1'b0;
            end
            etxnps_pkg::ST_RANK: begin
                if (scan_done) begin
                    r_v_idx   <= r_mn_idx;
                    r_v_node  <= r_mn_node;
                    r_prev_ok <= 1'b1;
                    r_prev    <= r_mn_node;
                    r_rank    <= r_rank + 1'b1;
                    r_mn_ok   <= 1'b0;
                end else if (r_rd_vld && u && (!r_prev_ok || rd_e.node > r_prev) &&
                             (!r_mn_ok || rd_e.node < r_mn_node)) begin
                    r_mn_ok   <= 1'b1;
                    r_mn_idx  <= r_rd_idx;
                    r_mn_node <= rd_e.node;
                end
            end
            etxnps_pkg::ST_SELECT: begin
                if (r_rd_vld && u) begin
                    if (rd_e.path_ok && rd_e.link_ok && !(r_cur_ok && rd_e.node == r_cur_id) &&
                        rd_e.parent != r_own &&
                        (rd_sum < r_b_sum || (r_b_ok && rd_sum == r_b_sum &&
                                              rd_e.node < r_b_node))) begin
                        r_b_ok   <= 1'b1;
                        r_b_node <= rd_e.node;
                        r_b_path <= rd_e.path;
                        r_b_link <= rd_e.link;
                        r_b_sum  <= rd_sum;
                    end
                    if (r_cur_ok && rd_e.node == r_cur_id) begin
                        r_p_ok <= 1'b1;
                        r_p_e  <= rd_e;
                    end
                end
            end
            etxnps_pkg::ST_SWITCH: begin
                r_pchg <= adopt;
            end
            default: ;
        endcase

        if (scan_start && n_state == etxnps_pkg::ST_SELECT) begin
            r_b_ok  <= 1'b0;
            r_b_sum <= etxnps_pkg::BEST_START;
            r_p_ok  <= 1'b0;
        end
    end

    always_comb begin
        out_word        = '0;
        out_word[15:0]  = r_cur_id;
        out_word[16]    = r_cur_ok;
        out_word[36:17] = is_root ? '0 : r_cpath;
        out_word[37]    = is_root ? 1'b1 : r_cpath_ok;
        out_word[38]    = r_pchg;
        out_word[39]    = is_root ? 1'b0 :
                          ((r_start_ok != r_cpath_ok) || (r_start != r_cpath));
        out_word[40]    = r_pull;
        out_word[41]    = r_stored;
        out_word[42]    = r_evk;
        out_word[58:43] = r_evid;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == etxnps_pkg::ST_DONE && (!r_m_valid || i_m_axis_tready)) begin
            r_m_data <= out_word;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

endmodule
